### rtl/core/cpch_pkg.sv
// ----------------------------------------------------------------------------
// cpch_pkg
// Shared types and constants for the code point classifier with Hangul split.
// ----------------------------------------------------------------------------
package cpch_pkg;

    localparam int CP_W    = 16;
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 5;

    // hangul syllable layout
    localparam logic [CP_W-1:0] HANGUL_FIRST      = 16'hAC00;
    localparam logic [CP_W-1:0] HANGUL_BLOCK_LAST = 16'hD7AF;
    localparam int              LEAD_COUNT        = 19;
    localparam int              VOWEL_COUNT       = 21;
    localparam int              TRAIL_COUNT       = 28;
    localparam int              PER_LEAD          = VOWEL_COUNT * TRAIL_COUNT;
    localparam int              SYLLABLE_COUNT    = LEAD_COUNT * PER_LEAD;

    // offset into the syllable range, wide enough for the whole hangul block
    localparam int SYL_W = 14;

    typedef enum logic [KIND_W-1:0] {
        KIND_CJK          = 3'd0,
        KIND_HANGUL       = 3'd1,
        KIND_HANGUL_UNASG = 3'd2,
        KIND_HIGH_SURR    = 3'd3,
        KIND_PRIV_HIGH    = 3'd4,
        KIND_LOW_SURR     = 3'd5,
        KIND_PRIVATE_USE  = 3'd6,
        KIND_OTHER        = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [INDEX_W-1:0] lead_index;
        logic [INDEX_W-1:0] vowel_index;
        logic [INDEX_W-1:0] trail_index;
        logic               ignorable;
        logic               frame_marker;
    } cpch_result_t;

endpackage

### rtl/core/cpch_classify.sv
// ----------------------------------------------------------------------------
// cpch_classify
// Combinational range classification, flag decode and Hangul jamo split.
// ----------------------------------------------------------------------------
module cpch_classify
    import cpch_pkg::*;
(
    input  logic [CP_W-1:0] code_point,
    output cpch_result_t    result
);

    logic               is_hangul_block;
    logic               is_syllable;
    logic [CP_W-1:0]    offset;
    logic [SYL_W-1:0]   syl;
    logic [11:0]        syl_q4;
    logic [20:0]        lead_prod;
    logic [INDEX_W-1:0] lead_est;
    logic [SYL_W-1:0]   lead_base;
    logic [SYL_W-1:0]   lead_rem_est;
    logic               lead_fix;
    logic [INDEX_W-1:0] lead;
    logic [9:0]         lead_rem;
    logic [7:0]         rem_q4;
    logic [18:0]        vowel_prod;
    logic [INDEX_W-1:0] vowel;
    logic [9:0]         vowel_base;
    logic [9:0]         trail_full;
    logic               ignorable;

    // hangul block offset
    assign is_hangul_block = (code_point >= HANGUL_FIRST) && (code_point <= HANGUL_BLOCK_LAST);
    assign offset          = code_point - HANGUL_FIRST;
    assign syl             = offset[SYL_W-1:0];
    assign is_syllable     = is_hangul_block && (syl < SYL_W'(SYLLABLE_COUNT));

    // lead = syl / 588 = (syl / 4) / 147, reciprocal 445 / 2^16 then one correction
    assign syl_q4       = syl[SYL_W-1:2];
    assign lead_prod    = 21'(syl_q4) * 21'd445;
    assign lead_est     = lead_prod[20:16];
    assign lead_base    = SYL_W'(lead_est) * SYL_W'(PER_LEAD);
    assign lead_rem_est = syl - lead_base;
    assign lead_fix     = (lead_rem_est >= SYL_W'(PER_LEAD));
    assign lead         = lead_fix ? lead_est + INDEX_W'(1) : lead_est;
    assign lead_rem     = lead_fix ? 10'(lead_rem_est - SYL_W'(PER_LEAD))
                                   : lead_rem_est[9:0];

    // vowel = rem / 28 = (rem / 4) / 7, reciprocal 293 / 2^11 is exact below 147
    assign rem_q4     = lead_rem[9:2];
    assign vowel_prod = 19'(rem_q4) * 19'd293;
    assign vowel      = vowel_prod[15:11];
    assign vowel_base = 10'(vowel) * 10'(TRAIL_COUNT);
    assign trail_full = lead_rem - vowel_base;

    // default-ignorable set
    assign ignorable = (code_point == 16'h00AD) || (code_point == 16'h034F)
                    || (code_point == 16'h115F) || (code_point == 16'h1160)
                    || (code_point == 16'h17B4) || (code_point == 16'h17B5)
                    || ((code_point >= 16'h180B) && (code_point <= 16'h180D))
                    || ((code_point >= 16'h200B) && (code_point <= 16'h200F))
                    || ((code_point >= 16'h202A) && (code_point <= 16'h202E))
                    || ((code_point >= 16'h2060) && (code_point <= 16'h206F))
                    || (code_point == 16'h3164)
                    || ((code_point >= 16'hFE00) && (code_point <= 16'hFE0F))
                    || (code_point == 16'hFEFF) || (code_point == 16'hFFA0)
                    || ((code_point >= 16'hFFF0) && (code_point <= 16'hFFF8));

    // kind by range, first match wins
    always_comb
    begin
        result = '0;
        priority if (((code_point >= 16'h3400) && (code_point <= 16'h4DB5))
                  || ((code_point >= 16'h4E00) && (code_point <= 16'h9FA5)))
        begin
            result.kind = KIND_CJK;
        end
        else if (is_syllable)
        begin
            result.kind        = KIND_HANGUL;
            result.lead_index  = lead;
            result.vowel_index = vowel;
            result.trail_index = trail_full[INDEX_W-1:0];
        end
        else if (is_hangul_block)
        begin
            result.kind = KIND_HANGUL_UNASG;
        end
        else if ((code_point >= 16'hD800) && (code_point <= 16'hDB7F))
        begin
            result.kind = KIND_HIGH_SURR;
        end
        else if ((code_point >= 16'hDB80) && (code_point <= 16'hDBFF))
        begin
            result.kind = KIND_PRIV_HIGH;
        end
        else if ((code_point >= 16'hDC00) && (code_point <= 16'hDFFF))
        begin
            result.kind = KIND_LOW_SURR;
        end
        else if ((code_point >= 16'hE000) && (code_point <= 16'hF8FF))
        begin
            result.kind = KIND_PRIVATE_USE;
        end
        else
        begin
            result.kind = KIND_OTHER;
        end
        result.ignorable    = ignorable;
        result.frame_marker = (code_point == 16'hFDD0) || (code_point == 16'hFDD1);
    end

endmodule

### rtl/core/codepoint_class_hangul_split.sv
// ----------------------------------------------------------------------------
// codepoint_class_hangul_split
// Sorts a 16-bit code point into a kind and splits Hangul syllables into jamo.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with code_point; a transfer happens on
// a rising edge where both are high.
// Output channel: out_valid / out_ready with kind, lead_index, vowel_index,
// trail_index, ignorable and frame_marker; exactly one result per input.
// Path: the code point lands in an input register; the classifier and jamo
// split work in one pass from there to the result register.
// Throughput: one code point per cycle while out_ready is high, limited by
// the single pass through the range compares and the two constant-reciprocal divides.
// Reset: rst_n clears both valid flags; nothing else is reset.
// Stall: while out_ready is low the result register holds, the input
// register fills behind it and in_ready then drops; ready paths are
// combinational back from out_ready.
// ----------------------------------------------------------------------------
module codepoint_class_hangul_split
    import cpch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CP_W-1:0]      code_point,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [INDEX_W-1:0]   lead_index,
    output logic [INDEX_W-1:0]   vowel_index,
    output logic [INDEX_W-1:0]   trail_index,
    output logic                 ignorable,
    output logic                 frame_marker
);

    logic            stg_valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            out_valid_reg;
    cpch_result_t    res_reg;
    cpch_result_t    res_next;
    logic            stg_ready;
    logic            in_xfer;

    // handshake
    assign stg_ready = !out_valid_reg || out_ready;
    assign in_ready  = !stg_valid_reg || stg_ready;
    assign in_xfer   = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cp_reg <= code_point;
        end
    end

    cpch_classify u_classify (
        .code_point (cp_reg),
        .result     (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_ready)
        begin
            out_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready && stg_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // outputs
    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign lead_index   = res_reg.lead_index;
    assign vowel_index  = res_reg.vowel_index;
    assign trail_index  = res_reg.trail_index;
    assign ignorable    = res_reg.ignorable;
    assign frame_marker = res_reg.frame_marker;

endmodule
